// ----- design/inverse_distance_weighted_average_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the inverse distance weighted average block
// Concurrent checks on clk_i, disabled in reset; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INVERSE_DISTANCE_WEIGHTED_AVERAGE_MACROS_SVH
`define INVERSE_DISTANCE_WEIGHTED_AVERAGE_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define IDWA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition must never be seen out of reset
`define IDWA_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IDWA_ASSERT(label, prop)
`define IDWA_ASSERT_NEVER(label, cond)
`endif
`endif

// ----- design/idwa_pkg.sv -----
// ----------------------------------------------------------------------------
// idwa_pkg
// Shared types and constants of the inverse distance weighted average block.
// ----------------------------------------------------------------------------
package idwa_pkg;

  localparam int unsigned DW  = 24;  // Q8.16 data
  localparam int unsigned WTW = 30;  // weight sum
  localparam int unsigned WRW = 54;  // weighted response sum
  localparam int unsigned PW  = 48;  // weight * response

  localparam logic [DW-1:0]  WEIGHT_ONE = 24'h010000;
  localparam logic [DW-1:0]  WEIGHT_MAX = 24'hFFFFFF;
  localparam logic [WRW-1:0] RECIP_NUM  = 54'h0_0001_0000_0000;
  localparam logic [DW-1:0]  PRED_MAX   = 24'h7FFFFF;
  localparam logic [DW-1:0]  PRED_MIN   = 24'h800000;

  typedef enum logic [1:0] {
    WCLS_ONE,    // below the floor
    WCLS_SAT,    // zero distance
    WCLS_RECIP   // needs a reciprocal
  } wcls_e;

  typedef struct packed {
    wcls_e                wcls;
    logic [DW-1:0]        distance;
    logic signed [DW-1:0] response;
    logic                 last;
  } nbr_t;

  typedef struct packed {
    logic           start;
    logic [WRW-1:0] dividend;
    logic [WTW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [WRW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/idwa_front.sv -----
// ----------------------------------------------------------------------------
// idwa_front
// Accepts neighbours, classifies their weight and queues them (two entries).
// ----------------------------------------------------------------------------
module idwa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,  // [23:0] distance, [47:24] response
  input  logic               s_axis_tlast,  // last_neighbor
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i,   // distance_floor
  input  logic               pop_i,
  output logic               avail_o,
  output idwa_pkg::nbr_t     item_o
);
  import idwa_pkg::*;

  logic [DW-1:0] floor_q;
  nbr_t          mem_q [2];
  logic [1:0]    cnt_q;
  logic          wr_ptr_q, rd_ptr_q;
  logic          push;
  nbr_t          in_item;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign avail_o       = (cnt_q != 2'd0);
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    in_item.distance = s_axis_tdata[DW-1:0];
    in_item.response = s_axis_tdata[2*DW-1:DW];
    in_item.last     = s_axis_tlast;
    if (in_item.distance < floor_q) begin
      in_item.wcls = WCLS_ONE;
    end else if (in_item.distance == '0) begin
      in_item.wcls = WCLS_SAT;
    end else begin
      in_item.wcls = WCLS_RECIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= 24'd1;
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        floor_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

// ----- design/idwa_div.sv -----
// ----------------------------------------------------------------------------
// idwa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idwa_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  idwa_pkg::div_req_t   req_i,
  output idwa_pkg::div_rsp_t   rsp_o
);
  import idwa_pkg::*;

  logic           busy_q, done_q;
  logic [5:0]     cnt_q;
  logic [WTW-1:0] rem_q, dvs_q;
  logic [WRW-1:0] quo_q;
  logic [WTW:0]   rem_sh, diff;
  logic           ge;

  assign rem_sh = {rem_q, quo_q[WRW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(WRW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WTW-1:0] : rem_sh[WTW-1:0];
      quo_q <= {quo_q[WRW-2:0], ge};
    end
  end

endmodule

// ----- design/idwa_back.sv -----
// ----------------------------------------------------------------------------
// idwa_back
// Sequencer: per neighbour weight, product, accumulation; per sample quotient.
// ----------------------------------------------------------------------------
module idwa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  idwa_pkg::nbr_t       item_i,
  output logic                 pop_o,
  output idwa_pkg::div_req_t   div_req_o,
  input  idwa_pkg::div_rsp_t   div_rsp_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata   // [23:0] prediction
);
  import idwa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RECIP, ST_MUL, ST_ACC, ST_QUOT, ST_OUT
  } state_e;

  state_e                state_q;
  nbr_t                  cur_q;
  logic [DW-1:0]         w_q, pred_q, out_q;
  logic signed [PW-1:0]  prod_q;
  logic [WTW-1:0]        wt_q, wt_n;
  logic [WRW-1:0]        wr_q, wr_n, mag;
  logic                  neg_q, outv_q;
  logic signed [PW:0]    prod_full;
  logic [WRW-1:0]        q;

  assign wt_n      = wt_q + {{(WTW-DW){1'b0}}, w_q};
  assign wr_n      = wr_q + {{(WRW-PW){prod_q[PW-1]}}, prod_q};
  assign mag       = wr_n[WRW-1] ? (~wr_n + 1'b1) : wr_n;
  assign prod_full = $signed({1'b0, w_q}) * cur_q.response;
  assign q         = div_rsp_i.quotient;

  assign pop_o = (state_q == ST_IDLE) && avail_i;

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = RECIP_NUM;
    div_req_o.divisor  = {{(WTW-DW){1'b0}}, item_i.distance};
    if (state_q == ST_IDLE && avail_i && item_i.wcls == WCLS_RECIP) begin
      div_req_o.start = 1'b1;
    end else if (state_q == ST_ACC && cur_q.last && wt_n != '0) begin
      div_req_o.start    = 1'b1;
      div_req_o.dividend = mag;
      div_req_o.divisor  = wt_n;
    end
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wt_q    <= '0;
      wr_q    <= '0;
      outv_q  <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!outv_q || m_axis_tready)) begin
        outv_q <= 1'b1;
      end else if (outv_q && m_axis_tready) begin
        outv_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (avail_i) begin
            cur_q <= item_i;
            case (item_i.wcls)
              WCLS_ONE: begin
                w_q     <= WEIGHT_ONE;
                state_q <= ST_MUL;
              end
              WCLS_SAT: begin
                w_q     <= WEIGHT_MAX;
                state_q <= ST_MUL;
              end
              default: state_q <= ST_RECIP;
            endcase
          end
        end
        ST_RECIP: begin
          if (div_rsp_i.done) begin
            w_q     <= (q > {{(WRW-DW){1'b0}}, WEIGHT_MAX}) ? WEIGHT_MAX : q[DW-1:0];
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_full[PW-1:0];
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (!cur_q.last) begin
            wt_q    <= wt_n;
            wr_q    <= wr_n;
            state_q <= ST_IDLE;
          end else begin
            wt_q  <= '0;
            wr_q  <= '0;
            neg_q <= wr_n[WRW-1];
            if (wt_n == '0) begin
              pred_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_QUOT;
            end
          end
        end
        ST_QUOT: begin
          if (div_rsp_i.done) begin
            if (neg_q) begin
              pred_q <= (q > {{(WRW-DW){1'b0}}, PRED_MIN}) ? PRED_MIN
                                                           : (~q[DW-1:0] + 1'b1);
            end else begin
              pred_q <= (q > {{(WRW-DW){1'b0}}, PRED_MAX}) ? PRED_MAX : q[DW-1:0];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!outv_q || m_axis_tready) begin
            out_q   <= pred_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/inverse_distance_weighted_average.sv -----
// ----------------------------------------------------------------------------
// inverse_distance_weighted_average
// k-NN regression: inverse distance weighted mean of a sample's neighbours.
// ----------------------------------------------------------------------------
// Neighbours enter on the slave stream into a two-entry queue and are worked
// one at a time by the back-end sequencer, which shares one bit-serial divider
// for reciprocals and quotients. A neighbour below the distance floor or at
// zero distance goes straight to multiply and accumulate; one needing a
// reciprocal first waits on a divider pass. The last neighbour of a sample adds
// a second divider pass before the prediction reaches the output register,
// which holds it while next neighbours are taken. No clearing pass after reset.
module inverse_distance_weighted_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] distance, [47:24] response
  input  logic        s_axis_tlast,   // last_neighbor
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] prediction
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i     // distance_floor
);
  import idwa_pkg::*;
  `include "inverse_distance_weighted_average_macros.svh"

  logic     avail, pop;
  nbr_t     item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  idwa_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .cfg_we_i, .cfg_wdata_i,
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (item)
  );

  idwa_div u_div (
    .clk_i, .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  idwa_back u_back (
    .clk_i, .rst_ni,
    .avail_i   (avail),
    .item_i    (item),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  `IDWA_ASSERT_NEVER(a_pop_empty, pop && !avail)
  `IDWA_ASSERT_NEVER(a_div_restart, div_req.start && div_rsp.busy)
  `IDWA_ASSERT(a_div_done_after_busy, div_rsp.done |-> $past(div_rsp.busy))

endmodule
